@@ design/lasp_pkg.sv @@
package lasp_pkg;

  localparam int NODE_W     = 10;
  localparam int NODE_DEPTH = 1 << NODE_W;
  localparam int COST_W     = 16;
  localparam int DIST_W     = 32;
  localparam int CFG_W      = 11;
  localparam int CNT_W      = 12;
  localparam int OUT_DIST_W = 30;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;

  localparam int DEF_MAX_NODES   = 1024;
  localparam int DEF_MAX_ENTRIES = 4096;
  localparam int DEF_HEAP_DEPTH  = 8192;

  localparam logic [DIST_W-1:0] UNREACHED = 32'h3f3f3f3f;
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam logic [CFG_W-1:0]  NUM_RESET = 11'd1024;

  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_UNREACH  = 2'd1,
    STATUS_OVERFLOW = 2'd2,
    STATUS_BAD_NODE = 2'd3
  } status_t;

  typedef struct packed {
    logic [DIST_W-1:0] prio;
    logic [NODE_W-1:0] node;
  } heap_item_t;

  typedef struct packed {
    logic [COST_W-1:0] rcost;
    logic [COST_W-1:0] ecost;
    logic              uneval;
  } pair_t;

  typedef enum logic [4:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_EDGE_B,
    ST_EDGE_RDA,
    ST_EDGE_A,
    ST_QUERY,
    ST_CLR,
    ST_SEED,
    ST_SEED_PUSH,
    ST_PUSH,
    ST_PUSH_UP,
    ST_PUSH_CMP,
    ST_POP_CHK,
    ST_POP_TOP,
    ST_POP_LAST,
    ST_POP_LOOP,
    ST_POP_C1,
    ST_POP_C2,
    ST_POP_DEC,
    ST_POP_END,
    ST_VISIT,
    ST_HEAD,
    ST_SCAN,
    ST_ENTRY,
    ST_RELAX,
    ST_DONE,
    ST_RESULT
  } state_t;

  // true when a leaves the heap before b
  function automatic logic goes_first(heap_item_t a, heap_item_t b);
    return (a.prio < b.prio) || ((a.prio == b.prio) && (a.node > b.node));
  endfunction

endpackage

@@ design/lazy_astar_shortest_path.sv @@
// Channel   Dir  Payload
// s_*       in   tuser: kind; tdata: node_a, node_b, real_weight, estimated_weight
// m_*       out  tdata: distance, evaluated_edges, status
// cfg_*     in   num_nodes write
// An edge request steps through ST_EDGE_B, ST_EDGE_RDA and ST_EDGE_A. A query runs
// two searches, each after a clearing sweep over num_nodes entries, made of heap steps
// and adjacency scans, paced by one registered read per memory per cycle.
// After reset all 1024 adjacency heads are cleared before s_tready rises.
// A finished result waits in the output register; the next request is taken
// meanwhile, and only a new result stalls on m_tready.
module lazy_astar_shortest_path #(
  parameter int MAX_NODES   = lasp_pkg::DEF_MAX_NODES,
  parameter int MAX_ENTRIES = lasp_pkg::DEF_MAX_ENTRIES,
  parameter int HEAP_DEPTH  = lasp_pkg::DEF_HEAP_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // node_a[9:0], node_b[19:10], real_weight[35:20], estimated_weight[51:36]
  input  logic [lasp_pkg::IN_DATA_W-1:0]  s_tdata,
  // kind
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // distance[29:0], evaluated_edges[41:30], status[43:42]
  output logic [lasp_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_wen,
  input  logic [lasp_pkg::CFG_W-1:0]      cfg_wdata
);
  import lasp_pkg::*;

  localparam int EW         = $clog2(MAX_ENTRIES);
  localparam int PAIR_DEPTH = (MAX_ENTRIES + 1) / 2;
  localparam int HW         = $clog2(HEAP_DEPTH);
  localparam int ENT_W      = EW + NODE_W;

  // memories
  logic [EW-1:0]     head_mem [NODE_DEPTH];
  logic [ENT_W-1:0]  ent_mem  [MAX_ENTRIES];
  pair_t             pair_mem [PAIR_DEPTH];
  logic [DIST_W-1:0] hdist_mem [NODE_DEPTH];
  logic [DIST_W-1:0] sdist_mem [NODE_DEPTH];
  logic              vis_mem  [NODE_DEPTH];
  heap_item_t        heap_mem [HEAP_DEPTH];

  logic [NODE_W-1:0] head_ra, head_wa;
  logic [EW-1:0]     head_rd, head_wd;
  logic              head_we;
  logic [EW-1:0]     ent_ra, ent_wa;
  logic [ENT_W-1:0]  ent_rd, ent_wd;
  logic              ent_we;
  logic [EW-2:0]     pair_ra, pair_wa;
  pair_t             pair_rd, pair_wd;
  logic              pair_we;
  logic [NODE_W-1:0] nra, dist_wa, vis_wa;
  logic [DIST_W-1:0] h_rd, s_rd, dist_wd;
  logic              dist_we, vis_rd, vis_we, vis_wd;
  logic [HW-1:0]     hp_ra, hp_wa;
  heap_item_t        hp_rd, hp_wd;
  logic              hp_we;
  logic              astar, astar_next;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_rd <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (pair_we) pair_mem[pair_wa] <= pair_wd;
    pair_rd <= pair_mem[pair_ra];
  end

  always_ff @(posedge clk) begin
    if (dist_we && !astar) hdist_mem[dist_wa] <= dist_wd;
    h_rd <= hdist_mem[nra];
  end

  always_ff @(posedge clk) begin
    if (dist_we && astar) sdist_mem[dist_wa] <= dist_wd;
    s_rd <= sdist_mem[nra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd <= vis_mem[nra];
  end

  always_ff @(posedge clk) begin
    if (hp_we) heap_mem[hp_wa] <= hp_wd;
    hp_rd <= heap_mem[hp_ra];
  end

  // control and working registers
  state_t            state, state_next, ret_state, ret_state_next;
  logic [CFG_W-1:0]  num_nodes;
  logic [CFG_W-1:0]  clr, clr_next;
  logic [HW:0]       heap_size, heap_size_next;
  logic [EW-1:0]     entry_count, entry_count_next;
  logic [CNT_W-1:0]  eval_cnt, eval_cnt_next;
  logic              ovf, ovf_next;
  logic              bad, bad_next;
  logic              out_valid, out_valid_next;
  logic [NODE_W-1:0] qa, qa_next, qb, qb_next, src, src_next, stop, stop_next;
  logic [COST_W-1:0] wr_cost, wr_cost_next, we_cost, we_cost_next;
  logic [NODE_W-1:0] top, top_next, tgt, tgt_next;
  logic [DIST_W-1:0] dnow, dnow_next, nd, nd_next;
  logic [EW-1:0]     e, e_next, enext, enext_next;
  heap_item_t        it, it_next, cand, cand_next, last, last_next;
  logic [HW-1:0]     pi, pi_next, cidx, cidx_next;
  logic [OUT_DIST_W-1:0] res_dist, res_dist_next;
  logic [CNT_W-1:0]  res_cnt, res_cnt_next;
  status_t           res_status, res_status_next;

  logic [NODE_W-1:0] in_a, in_b;
  logic [HW:0]       cpos;
  logic [EW-1:0]     k1, k2;
  logic [DIST_W-1:0] dist_rd, relax_sum, fin_dist;
  logic [COST_W-1:0] cost;
  pair_t             ent_pair;

  assign in_a     = s_tdata[9:0];
  assign in_b     = s_tdata[19:10];
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, res_status, res_cnt, res_dist};
  assign cpos     = {pi, 1'b1};
  assign k1       = entry_count + EW'(1);
  assign k2       = entry_count + EW'(2);
  assign dist_rd  = astar ? s_rd : h_rd;
  assign ent_pair = pair_rd;
  assign cost     = (astar || !ent_pair.uneval) ? ent_pair.rcost : ent_pair.ecost;
  assign relax_sum = h_rd + nd;
  assign fin_dist = s_rd;

  function automatic logic node_ok(logic [NODE_W-1:0] v, logic [CFG_W-1:0] n);
    return (v != '0) && (CFG_W'(v) <= n);
  endfunction

  always_comb begin
    state_next       = state;
    ret_state_next   = ret_state;
    clr_next         = clr;
    heap_size_next   = heap_size;
    entry_count_next = entry_count;
    eval_cnt_next    = eval_cnt;
    ovf_next         = ovf;
    astar_next       = astar;
    bad_next         = bad;
    out_valid_next   = out_valid && !m_tready;
    qa_next          = qa;
    qb_next          = qb;
    src_next         = src;
    stop_next        = stop;
    wr_cost_next     = wr_cost;
    we_cost_next     = we_cost;
    top_next         = top;
    tgt_next         = tgt;
    dnow_next        = dnow;
    nd_next          = nd;
    e_next           = e;
    enext_next       = enext;
    it_next          = it;
    cand_next        = cand;
    last_next        = last;
    pi_next          = pi;
    cidx_next        = cidx;
    res_dist_next    = res_dist;
    res_cnt_next     = res_cnt;
    res_status_next  = res_status;

    head_ra = '0; head_we = 1'b0; head_wa = '0; head_wd = '0;
    ent_ra  = e;  ent_we  = 1'b0; ent_wa  = '0; ent_wd  = '0;
    pair_ra = e[EW-1:1]; pair_we = 1'b0; pair_wa = e[EW-1:1]; pair_wd = ent_pair;
    nra     = tgt; dist_we = 1'b0; dist_wa = '0; dist_wd = '0;
    vis_we  = 1'b0; vis_wa = '0; vis_wd = 1'b0;
    hp_ra   = '0; hp_we = 1'b0; hp_wa = pi; hp_wd = it;

    unique case (state)
      ST_INIT_CLR: begin
        head_we = 1'b1;
        head_wa = clr[NODE_W-1:0];
        if (clr == CFG_W'(NODE_DEPTH - 1)) begin
          clr_next   = '0;
          state_next = ST_IDLE;
        end else begin
          clr_next = clr + CFG_W'(1);
        end
      end
      ST_IDLE: begin
        head_ra = in_b;
        if (s_tvalid) begin
          qa_next      = in_a;
          qb_next      = in_b;
          wr_cost_next = s_tdata[35:20];
          we_cost_next = s_tdata[51:36];
          if (s_tuser == KIND_QUERY) begin
            state_next = ST_QUERY;
          end else if (node_ok(in_a, num_nodes) && node_ok(in_b, num_nodes)) begin
            if (32'(entry_count) + 2 >= MAX_ENTRIES) ovf_next = 1'b1;
            else state_next = ST_EDGE_B;
          end
        end
      end
      ST_EDGE_B: begin
        ent_we  = 1'b1;
        ent_wa  = k1;
        ent_wd  = {head_rd, qa};
        head_we = 1'b1;
        head_wa = qb;
        head_wd = k1;
        pair_we = 1'b1;
        pair_wa = k1[EW-1:1];
        pair_wd = '{rcost: wr_cost, ecost: we_cost, uneval: 1'b1};
        state_next = ST_EDGE_RDA;
      end
      ST_EDGE_RDA: begin
        head_ra    = qa;
        state_next = ST_EDGE_A;
      end
      ST_EDGE_A: begin
        ent_we  = 1'b1;
        ent_wa  = k2;
        ent_wd  = {head_rd, qb};
        head_we = 1'b1;
        head_wa = qa;
        head_wd = k2;
        entry_count_next = k2;
        state_next = ST_IDLE;
      end
      ST_QUERY: begin
        if (!node_ok(qa, num_nodes) || !node_ok(qb, num_nodes)) begin
          bad_next   = 1'b1;
          state_next = ST_RESULT;
        end else begin
          bad_next   = 1'b0;
          astar_next = 1'b0;
          src_next   = qb;
          stop_next  = qa;
          clr_next   = CFG_W'(1);
          state_next = ST_CLR;
        end
      end
      ST_CLR: begin
        vis_we  = 1'b1;
        vis_wa  = clr[NODE_W-1:0];
        dist_we = 1'b1;
        dist_wa = clr[NODE_W-1:0];
        dist_wd = UNREACHED;
        if (clr >= num_nodes || clr == CFG_W'(NODE_DEPTH - 1)) begin
          heap_size_next = '0;
          state_next     = ST_SEED;
        end else begin
          clr_next = clr + CFG_W'(1);
        end
      end
      ST_SEED: begin
        dist_we    = 1'b1;
        dist_wa    = src;
        dist_wd    = '0;
        nra        = src;
        state_next = ST_SEED_PUSH;
      end
      ST_SEED_PUSH: begin
        it_next        = '{prio: astar ? h_rd : '0, node: src};
        ret_state_next = ST_POP_CHK;
        state_next     = ST_PUSH;
      end
      ST_PUSH: begin
        if (32'(heap_size) >= HEAP_DEPTH) begin
          state_next = ret_state;
        end else begin
          pi_next        = heap_size[HW-1:0];
          heap_size_next = heap_size + (HW+1)'(1);
          state_next     = ST_PUSH_UP;
        end
      end
      ST_PUSH_UP: begin
        hp_ra = (pi - HW'(1)) >> 1;
        if (pi == '0) begin
          hp_we      = 1'b1;
          state_next = ret_state;
        end else begin
          state_next = ST_PUSH_CMP;
        end
      end
      ST_PUSH_CMP: begin
        hp_we = 1'b1;
        if (goes_first(it, hp_rd)) begin
          hp_wd      = hp_rd;
          pi_next    = (pi - HW'(1)) >> 1;
          state_next = ST_PUSH_UP;
        end else begin
          state_next = ret_state;
        end
      end
      ST_POP_CHK: begin
        hp_ra = '0;
        if (heap_size == '0) state_next = ST_DONE;
        else state_next = ST_POP_TOP;
      end
      ST_POP_TOP: begin
        top_next       = hp_rd.node;
        heap_size_next = heap_size - (HW+1)'(1);
        hp_ra          = heap_size_next[HW-1:0];
        state_next     = ST_POP_LAST;
      end
      ST_POP_LAST: begin
        last_next  = hp_rd;
        pi_next    = '0;
        state_next = ST_POP_LOOP;
      end
      ST_POP_LOOP: begin
        hp_ra = cpos[HW-1:0];
        if (cpos >= heap_size) state_next = ST_POP_END;
        else state_next = ST_POP_C1;
      end
      ST_POP_C1: begin
        cand_next = hp_rd;
        cidx_next = cpos[HW-1:0];
        hp_ra     = cpos[HW-1:0] + HW'(1);
        if (cpos + (HW+1)'(1) < heap_size) state_next = ST_POP_C2;
        else state_next = ST_POP_DEC;
      end
      ST_POP_C2: begin
        if (goes_first(hp_rd, cand)) begin
          cand_next = hp_rd;
          cidx_next = cpos[HW-1:0] + HW'(1);
        end
        state_next = ST_POP_DEC;
      end
      ST_POP_DEC: begin
        if (goes_first(cand, last)) begin
          hp_we      = 1'b1;
          hp_wd      = cand;
          pi_next    = cidx;
          state_next = ST_POP_LOOP;
        end else begin
          state_next = ST_POP_END;
        end
      end
      ST_POP_END: begin
        hp_wd      = last;
        hp_we      = (heap_size != '0);
        nra        = top;
        state_next = ST_VISIT;
      end
      ST_VISIT: begin
        head_ra = top;
        if (vis_rd) begin
          state_next = ST_POP_CHK;
        end else begin
          vis_we    = 1'b1;
          vis_wa    = top;
          vis_wd    = 1'b1;
          dnow_next = dist_rd;
          if (top == stop) state_next = ST_DONE;
          else state_next = ST_HEAD;
        end
      end
      ST_HEAD: begin
        e_next     = head_rd;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (e == '0) state_next = ST_POP_CHK;
        else state_next = ST_ENTRY;
      end
      ST_ENTRY: begin
        tgt_next   = ent_rd[NODE_W-1:0];
        enext_next = ent_rd[ENT_W-1:NODE_W];
        nd_next    = dnow + DIST_W'(cost);
        nra        = ent_rd[NODE_W-1:0];
        // first use of an edge in the A* pass: both directions share one pair entry
        if (astar && ent_pair.uneval) begin
          pair_we       = 1'b1;
          pair_wd       = '{rcost: ent_pair.rcost, ecost: ent_pair.ecost, uneval: 1'b0};
          if (eval_cnt != CNT_MAX) eval_cnt_next = eval_cnt + CNT_W'(1);
        end
        if (node_ok(ent_rd[NODE_W-1:0], num_nodes)) begin
          state_next = ST_RELAX;
        end else begin
          e_next     = ent_rd[ENT_W-1:NODE_W];
          state_next = ST_SCAN;
        end
      end
      ST_RELAX: begin
        e_next = enext;
        if (nd < dist_rd) begin
          dist_we        = 1'b1;
          dist_wa        = tgt;
          dist_wd        = nd;
          it_next        = '{prio: astar ? relax_sum : nd, node: tgt};
          ret_state_next = ST_SCAN;
          state_next     = ST_PUSH;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_DONE: begin
        nra = qb;
        if (!astar) begin
          astar_next = 1'b1;
          src_next   = qa;
          stop_next  = qb;
          clr_next   = CFG_W'(1);
          state_next = ST_CLR;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        nra = qb;
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          res_cnt_next   = eval_cnt;
          if (bad) begin
            res_dist_next   = UNREACHED[OUT_DIST_W-1:0];
            res_status_next = STATUS_BAD_NODE;
          end else begin
            res_dist_next = fin_dist[OUT_DIST_W-1:0];
            if (ovf) res_status_next = STATUS_OVERFLOW;
            else if (fin_dist >= UNREACHED) res_status_next = STATUS_UNREACH;
            else res_status_next = STATUS_OK;
          end
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT_CLR;
      ret_state   <= ST_POP_CHK;
      clr         <= '0;
      heap_size   <= '0;
      entry_count <= EW'(1);
      eval_cnt    <= '0;
      ovf         <= 1'b0;
      astar       <= 1'b0;
      bad         <= 1'b0;
      out_valid   <= 1'b0;
      num_nodes   <= (32'(NUM_RESET) > MAX_NODES) ? CFG_W'(MAX_NODES) : NUM_RESET;
    end else begin
      state       <= state_next;
      ret_state   <= ret_state_next;
      clr         <= clr_next;
      heap_size   <= heap_size_next;
      entry_count <= entry_count_next;
      eval_cnt    <= eval_cnt_next;
      ovf         <= ovf_next;
      astar       <= astar_next;
      bad         <= bad_next;
      out_valid   <= out_valid_next;
      if (cfg_wen) begin
        if (cfg_wdata == '0) num_nodes <= CFG_W'(1);
        else if (32'(cfg_wdata) > MAX_NODES) num_nodes <= CFG_W'(MAX_NODES);
        else num_nodes <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    qa         <= qa_next;
    qb         <= qb_next;
    src        <= src_next;
    stop       <= stop_next;
    wr_cost    <= wr_cost_next;
    we_cost    <= we_cost_next;
    top        <= top_next;
    tgt        <= tgt_next;
    dnow       <= dnow_next;
    nd         <= nd_next;
    e          <= e_next;
    enext      <= enext_next;
    it         <= it_next;
    cand       <= cand_next;
    last       <= last_next;
    pi         <= pi_next;
    cidx       <= cidx_next;
    res_dist   <= res_dist_next;
    res_cnt    <= res_cnt_next;
    res_status <= res_status_next;
  end

  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    32'(heap_size) <= HEAP_DEPTH)
    else $error("heap size beyond depth");

  a_entry_odd: assert property (@(posedge clk) disable iff (rst)
    entry_count[0] == 1'b1)
    else $error("entry count lost pair alignment");

  a_eval_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> eval_cnt >= $past(eval_cnt))
    else $error("evaluated edge count decreased");

  a_edge_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EDGE_A) |=> !$rose(out_valid))
    else $error("edge request produced a result");

endmodule
